### design/hkv_pkg.sv
// Shared word format, constants and saturating helpers for the kick-drum voice.
package hkv_pkg;

    localparam int COEF_WIDTH       = 32;
    localparam int FRAC             = 28;
    localparam int FADE_SAMPLES     = 480;
    localparam int MAX_NOTE_SAMPLES = 40800;

    typedef logic signed [COEF_WIDTH-1:0] t_word;

    localparam t_word ONE         = t_word'(268435456);
    localparam t_word LIN_DT      = t_word'(257541);
    localparam t_word NL_DT       = t_word'(587203);
    localparam t_word U_CAP       = t_word'(375809638);
    localparam t_word GATE_CAP    = t_word'(402653184);
    localparam t_word KNOCK_DECAY = t_word'(267034354);
    localparam t_word CHUFF_DECAY = t_word'(268355576);
    localparam t_word LP_COEF     = t_word'(40517463);
    localparam t_word HP_COEF     = t_word'(8642348);
    localparam t_word KNOCK_MIX   = t_word'(34896609);
    localparam t_word NOISE_MIX   = t_word'(147639501);
    localparam t_word OUT_GAIN    = t_word'(241591910);

    localparam logic [2:0] REG_ROTATION   = 3'd0;
    localparam logic [2:0] REG_FORCE_PEAK = 3'd1;
    localparam logic [2:0] REG_FALL       = 3'd2;
    localparam logic [2:0] REG_RISE_FALL  = 3'd3;
    localparam logic [2:0] REG_KNOCK_ROT  = 3'd4;
    localparam logic [2:0] REG_KNOCK_RAT  = 3'd5;
    localparam logic [2:0] REG_SEED       = 3'd6;
    localparam logic [2:0] REG_LENGTH     = 3'd7;

    function automatic t_word sat_wide(input logic signed [COEF_WIDTH:0] v);
        t_word r;
        if (v[COEF_WIDTH] != v[COEF_WIDTH-1])
            r = v[COEF_WIDTH] ? {1'b1, {(COEF_WIDTH-1){1'b0}}} : {1'b0, {(COEF_WIDTH-1){1'b1}}};
        else
            r = v[COEF_WIDTH-1:0];
        return r;
    endfunction

    function automatic t_word sat_add(input t_word a, input t_word b);
        return sat_wide({a[COEF_WIDTH-1], a} + {b[COEF_WIDTH-1], b});
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        return sat_wide({a[COEF_WIDTH-1], a} - {b[COEF_WIDTH-1], b});
    endfunction

endpackage

### design/helmholtz_kick_voice_unit.sv
// Kick-drum voice: sequenced fixed-point sample renderer with APB register file.
// Usage:
//   Input stream (i_s_*): one transfer per sample; tdata bit 0 is strike.
//   A strike clears the voice and renders sample 0 of a new note, a plain
//   transfer renders the next sample.
//   Output stream (o_m_*): one transfer per input transfer. tdata is the
//   signed Q1.15 sample, tuser is note_active, tlast marks the final sample.
//   APB port: eight registers at byte addresses 0,4,...,28, to be written by
//   the user only while no sample is in flight; the block does not enforce it.
// Sequence: each item passes through the fade gain (a reciprocal product),
//   23 multiply steps on the single shared 32x32 multiplier, a done state that
//   moves the result into the output register and an idle state that takes
//   the next transfer; a new item is taken only after the last one is through.
//   An item past the note end skips the fade gain and the multiply steps and
//   goes straight to the done state with a zero result.
//   o_s_tready is high only while the sequencer is idle.
// Reset: registers take their reset values, the voice stands at the start
//   of a note with noise state 1, and the output is empty.
// Stall: a finished result waits in the output register; the sequencer
//   holds at its end until the register is free.
module helmholtz_kick_voice_unit #(
    parameter int FADE_SAMPLES     = hkv_pkg::FADE_SAMPLES,
    parameter int MAX_NOTE_SAMPLES = hkv_pkg::MAX_NOTE_SAMPLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [0] strike, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [15:0] sample
    output logic        o_m_tuser,    // [0] note_active
    output logic        o_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    localparam int W      = hkv_pkg::COEF_WIDTH;
    localparam int F      = hkv_pkg::FRAC;
    localparam int QW     = F + 1;
    localparam int LAST_STEP = 22;
    localparam logic [15:0] MAX_LEN = 16'(MAX_NOTE_SAMPLES);
    // ceil(2^52 / FADE_SAMPLES); gain = (n * FADE_RECIP) >> 24 is exact for n up to 4096
    localparam logic [52:0] FADE_RECIP =
        53'(((64'd1 << 52) + 64'(FADE_SAMPLES - 1)) / 64'(FADE_SAMPLES));

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_CALC, S_DONE} t_state;
    typedef hkv_pkg::t_word t_word;

    t_state r_state;
    logic [29:0] r_rc, r_krc;
    logic [30:0] r_fp;
    logic [28:0] r_ff, r_rff, r_kfr;
    logic [31:0] r_seed;
    logic [15:0] r_len;

    logic [15:0] r_idx;
    t_word r_px, r_pv, r_kx, r_kv, r_fe, r_rfe, r_ce, r_lp1, r_lp2, r_hp;
    logic [31:0] r_noise;
    t_word r_force, r_u, r_ddt, r_damp, r_y, r_ta, r_tb;
    logic signed [2*W-1:0] r_prod;
    logic [4:0] r_step;
    logic r_phase;
    logic [15:0] r_num;
    logic [QW-1:0] r_quot;
    logic [15:0] r_res;
    logic r_res_act, r_res_last;
    logic r_out_valid;
    logic [15:0] r_out_data;
    logic r_out_user, r_out_last;

    logic cfg_wr;
    logic [15:0] len_eff, idx_start, n_idx;
    logic accept, strike, ken, fading, out_load;
    t_word mul_a, mul_b, qm, env_diff, au, w_noise, band;
    logic [31:0] rn;
    logic [W:0] uabs;
    logic signed [2*W-F-1:0] p_sh;
    logic [65:0] fade_prod;
    logic [W-F+15-1:0] out_sh;
    logic [15:0] out_sat;

    assign o_pready = 1'b1;
    assign cfg_wr = i_psel && i_penable && i_pwrite;
    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign strike = i_s_tdata[0];
    assign len_eff = (r_len > MAX_LEN) ? MAX_LEN : r_len;
    assign idx_start = strike ? 16'd0 : r_idx;
    assign ken = (r_krc != '0);
    assign fading = ({1'b0, r_idx} + 17'(FADE_SAMPLES)) >= {1'b0, len_eff};
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        case (i_paddr[4:2])
            hkv_pkg::REG_ROTATION:   o_prdata = {2'b0, r_rc};
            hkv_pkg::REG_FORCE_PEAK: o_prdata = {1'b0, r_fp};
            hkv_pkg::REG_FALL:       o_prdata = {3'b0, r_ff};
            hkv_pkg::REG_RISE_FALL:  o_prdata = {3'b0, r_rff};
            hkv_pkg::REG_KNOCK_ROT:  o_prdata = {2'b0, r_krc};
            hkv_pkg::REG_KNOCK_RAT:  o_prdata = {3'b0, r_kfr};
            hkv_pkg::REG_SEED:       o_prdata = r_seed;
            hkv_pkg::REG_LENGTH:     o_prdata = {16'b0, r_len};
            default:                 o_prdata = '0;
        endcase
    end

    // operand preparation
    always_comb begin
        env_diff = hkv_pkg::sat_sub(r_fe, r_rfe);
        uabs = r_u[W-1] ? -{r_u[W-1], r_u} : {r_u[W-1], r_u};
        au = ($signed(uabs) > $signed({1'b0, hkv_pkg::U_CAP})) ? hkv_pkg::U_CAP : uabs[W-1:0];
        rn = r_noise ^ (r_noise << 13);
        rn = rn ^ (rn >> 17);
        rn = rn ^ (rn << 5);
        w_noise = t_word'({rn[31:8], 5'b0}) - hkv_pkg::ONE;
        band = hkv_pkg::sat_sub(r_lp2, r_hp);
    end

    always_comb begin
        case (r_step)
            5'd0:  begin mul_a = t_word'(r_fp);  mul_b = env_diff; end
            5'd1:  begin mul_a = hkv_pkg::NL_DT; mul_b = au; end
            5'd2:  begin mul_a = r_ddt; mul_b = r_ddt; end
            5'd3:  begin mul_a = r_pv; mul_b = r_damp; end
            5'd4:  begin mul_a = t_word'(r_rc); mul_b = r_px; end
            5'd5:  begin mul_a = t_word'(r_rc); mul_b = r_pv; end
            5'd6:  begin mul_a = r_kv; mul_b = hkv_pkg::KNOCK_DECAY; end
            5'd7:  begin mul_a = r_force; mul_b = t_word'(r_kfr); end
            5'd8:  begin mul_a = t_word'(r_krc); mul_b = r_kx; end
            5'd9:  begin mul_a = t_word'(r_krc); mul_b = r_kv; end
            5'd10: begin mul_a = hkv_pkg::KNOCK_MIX; mul_b = r_kv; end
            5'd11: begin mul_a = hkv_pkg::LP_COEF;
                         mul_b = hkv_pkg::sat_sub(w_noise, r_lp1); end
            5'd12: begin mul_a = hkv_pkg::LP_COEF;
                         mul_b = hkv_pkg::sat_sub(r_lp1, r_lp2); end
            5'd13: begin mul_a = hkv_pkg::HP_COEF;
                         mul_b = hkv_pkg::sat_sub(r_lp2, r_hp); end
            5'd14: begin mul_a = r_u; mul_b = r_u; end
            5'd15: begin mul_a = hkv_pkg::NOISE_MIX; mul_b = band; end
            5'd16: begin mul_a = r_tb; mul_b = r_ta; end
            5'd17: begin mul_a = r_tb; mul_b = r_ce; end
            5'd18: begin mul_a = r_y; mul_b = t_word'(r_quot); end
            5'd19: begin mul_a = hkv_pkg::OUT_GAIN; mul_b = r_y; end
            5'd20: begin mul_a = r_fe; mul_b = t_word'(r_ff); end
            5'd21: begin mul_a = r_rfe; mul_b = t_word'(r_rff); end
            5'd22: begin mul_a = r_ce; mul_b = hkv_pkg::CHUFF_DECAY; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // floored product, saturated to the word
    always_comb begin
        p_sh = r_prod[2*W-1:F];
        if (p_sh > $signed({{(W-F){1'b0}}, 1'b0, {(W-1){1'b1}}}))
            qm = {1'b0, {(W-1){1'b1}}};
        else if (p_sh < $signed({{(W-F){1'b1}}, 1'b1, {(W-1){1'b0}}}))
            qm = {1'b1, {(W-1){1'b0}}};
        else
            qm = p_sh[W-1:0];
        out_sh = qm[W-1:F-15];
        if ($signed(out_sh) > $signed((W-F+15)'(32767)))
            out_sat = 16'h7FFF;
        else if ($signed(out_sh) < -$signed((W-F+15)'(32768)))
            out_sat = 16'h8000;
        else
            out_sat = out_sh[15:0];
        fade_prod = 66'(r_num[12:0]) * 66'(FADE_RECIP);
        n_idx = r_idx + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= '0; r_fp <= '0; r_ff <= '0; r_rff <= '0;
            r_krc <= '0; r_kfr <= '0; r_seed <= 32'd1; r_len <= '0;
        end else if (cfg_wr) begin
            case (i_paddr[4:2])
                hkv_pkg::REG_ROTATION:   r_rc   <= i_pwdata[29:0];
                hkv_pkg::REG_FORCE_PEAK: r_fp   <= i_pwdata[30:0];
                hkv_pkg::REG_FALL:       r_ff   <= i_pwdata[28:0];
                hkv_pkg::REG_RISE_FALL:  r_rff  <= i_pwdata[28:0];
                hkv_pkg::REG_KNOCK_ROT:  r_krc  <= i_pwdata[29:0];
                hkv_pkg::REG_KNOCK_RAT:  r_kfr  <= i_pwdata[28:0];
                hkv_pkg::REG_SEED:       r_seed <= i_pwdata;
                hkv_pkg::REG_LENGTH:     r_len  <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx <= '0;
            r_px <= '0; r_pv <= '0; r_kx <= '0; r_kv <= '0;
            r_lp1 <= '0; r_lp2 <= '0; r_hp <= '0;
            r_fe <= hkv_pkg::ONE; r_rfe <= hkv_pkg::ONE; r_ce <= hkv_pkg::ONE;
            r_noise <= 32'd1;
            r_step <= '0; r_phase <= 1'b0;
        end else begin
            if (out_load)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (strike) begin
                            r_idx <= '0;
                            r_px <= '0; r_pv <= '0; r_kx <= '0; r_kv <= '0;
                            r_lp1 <= '0; r_lp2 <= '0; r_hp <= '0;
                            r_fe <= hkv_pkg::ONE; r_rfe <= hkv_pkg::ONE;
                            r_ce <= hkv_pkg::ONE;
                            r_noise <= (r_seed != '0) ? r_seed : 32'd1;
                        end
                        r_step <= '0;
                        r_phase <= 1'b0;
                        r_num <= len_eff - idx_start;
                        if (idx_start >= len_eff) begin
                            r_res <= '0; r_res_act <= 1'b0; r_res_last <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quot <= fade_prod[52:24];
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        case (r_step)
                            5'd0:  begin r_force <= qm; r_u <= r_pv; end
                            5'd1:  r_ddt <= hkv_pkg::LIN_DT + qm;
                            5'd2:  r_damp <= hkv_pkg::ONE - r_ddt + (qm >>> 1);
                            5'd3:  r_pv <= qm;
                            5'd4:  r_pv <= hkv_pkg::sat_add(hkv_pkg::sat_sub(r_pv, qm), r_force);
                            5'd5:  begin r_px <= hkv_pkg::sat_add(r_px, qm); r_y <= r_pv; end
                            5'd6:  if (ken) r_kv <= qm;
                            5'd7:  r_ta <= qm;
                            5'd8:  if (ken) r_kv <= hkv_pkg::sat_add(hkv_pkg::sat_sub(r_kv, qm), r_ta);
                            5'd9:  if (ken) r_kx <= hkv_pkg::sat_add(r_kx, qm);
                            5'd10: if (ken) r_y <= hkv_pkg::sat_add(r_y, qm);
                            5'd11: begin r_lp1 <= hkv_pkg::sat_add(r_lp1, qm); r_noise <= rn; end
                            5'd12: r_lp2 <= hkv_pkg::sat_add(r_lp2, qm);
                            5'd13: r_hp <= hkv_pkg::sat_add(r_hp, qm);
                            5'd14: r_ta <= (qm > hkv_pkg::GATE_CAP) ? hkv_pkg::GATE_CAP : qm;
                            5'd15: r_tb <= qm;
                            5'd16: r_tb <= qm;
                            5'd17: r_y <= hkv_pkg::sat_add(r_y, qm);
                            5'd18: if (fading) r_y <= qm;
                            5'd19: begin
                                r_res <= out_sat;
                                r_res_act <= 1'b1;
                                r_res_last <= (n_idx == len_eff);
                            end
                            5'd20: r_fe <= qm;
                            5'd21: r_rfe <= qm;
                            5'd22: begin r_ce <= qm; r_idx <= n_idx; end
                            default: ;
                        endcase
                        r_step <= r_step + 1'b1;
                        if (r_step == 5'(LAST_STEP))
                            r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_data <= r_res;
                        r_out_user <= r_res_act;
                        r_out_last <= r_res_last;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### bench/testbench.sv
// Self-checking bench for the kick-drum voice: streamed samples against a fixed-point predictor.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [15:0] sample;
        logic        active;
        logic        last;
    } t_voice_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;    // [0] strike, [7:1] zero
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;           // [15:0] sample
    logic        o_m_tuser;           // [0] note_active
    logic        o_m_tlast;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [4:0]  i_paddr = 5'd0;
    logic [31:0] i_pwdata = 32'd0;
    logic [31:0] o_prdata;
    logic        o_pready;

    helmholtz_kick_voice_unit dut (.*);

    // voice model state
    longint rot_c, force_pk, fall_f, rf_f, knock_rot, knock_rat, seed_r, len_r;
    longint idx, disp, vel, kdisp, kvel, env_fall, env_rf, env_chuff, lp1, lp2, hp;
    logic [31:0] noise;

    t_voice_out pending_samples[$];
    int  errors = 0;
    bit  calm = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint wsat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qm(longint a, longint b);
        longint p;
        p = a * b;
        return wsat(p >>> hkv_pkg::FRAC);
    endfunction

    function automatic void clear_voice();
        idx = 0; disp = 0; vel = 0; kdisp = 0; kvel = 0;
        env_fall = hkv_pkg::ONE; env_rf = hkv_pkg::ONE; env_chuff = hkv_pkg::ONE;
        lp1 = 0; lp2 = 0; hp = 0;
    endfunction

    function automatic t_voice_out render_sample(bit strike);
        t_voice_out o;
        longint lenE, beat, u, au, ddt, damp, y, w, band, gate, g, q;
        logic [31:0] r;
        o = '0;
        lenE = (len_r > hkv_pkg::MAX_NOTE_SAMPLES) ? hkv_pkg::MAX_NOTE_SAMPLES : len_r;
        if (strike) begin
            clear_voice();
            noise = (seed_r != 0) ? seed_r[31:0] : 32'd1;
        end
        if (idx >= lenE) return o;
        beat = qm(force_pk, wsat(env_fall - env_rf));
        u = vel;
        au = (u < 0) ? -u : u;
        if (au > hkv_pkg::U_CAP) au = hkv_pkg::U_CAP;
        ddt = hkv_pkg::LIN_DT + qm(hkv_pkg::NL_DT, au);
        damp = hkv_pkg::ONE - ddt + (qm(ddt, ddt) >>> 1);
        vel = qm(vel, damp);
        vel = wsat(wsat(vel - qm(rot_c, disp)) + beat);
        disp = wsat(disp + qm(rot_c, vel));
        y = vel;
        if (knock_rot != 0) begin
            kvel = qm(kvel, hkv_pkg::KNOCK_DECAY);
            kvel = wsat(wsat(kvel - qm(knock_rot, kdisp)) + qm(beat, knock_rat));
            kdisp = wsat(kdisp + qm(knock_rot, kvel));
            y = wsat(y + qm(hkv_pkg::KNOCK_MIX, kvel));
        end
        r = noise;
        r ^= r << 13; r ^= r >> 17; r ^= r << 5;
        noise = r;
        w = (longint'(r >> 8) << 5) - hkv_pkg::ONE;
        lp1 = wsat(lp1 + qm(hkv_pkg::LP_COEF, wsat(w - lp1)));
        lp2 = wsat(lp2 + qm(hkv_pkg::LP_COEF, wsat(lp1 - lp2)));
        hp = wsat(hp + qm(hkv_pkg::HP_COEF, wsat(lp2 - hp)));
        band = wsat(lp2 - hp);
        gate = qm(u, u);
        if (gate > hkv_pkg::GATE_CAP) gate = hkv_pkg::GATE_CAP;
        y = wsat(y + qm(qm(qm(hkv_pkg::NOISE_MIX, band), gate), env_chuff));
        if (idx >= lenE - hkv_pkg::FADE_SAMPLES) begin
            g = ((lenE - idx) << hkv_pkg::FRAC) / hkv_pkg::FADE_SAMPLES;
            y = qm(y, g);
        end
        q = qm(hkv_pkg::OUT_GAIN, y) >>> (hkv_pkg::FRAC - 15);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        env_fall = qm(env_fall, fall_f);
        env_rf = qm(env_rf, rf_f);
        env_chuff = qm(env_chuff, hkv_pkg::CHUFF_DECAY);
        idx = idx + 1;
        o.sample = q[15:0];
        o.active = 1'b1;
        o.last = (idx == lenE);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_voice_out e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected transfer", o_m_tdata, 0);
            end else begin
                e = pending_samples.pop_front();
                if (o_m_tdata !== e.sample)
                    report_mismatch("sample", $signed(o_m_tdata), $signed(e.sample));
                if (o_m_tuser !== e.active) report_mismatch("note_active", o_m_tuser, e.active);
                if (o_m_tlast !== e.last) report_mismatch("last_of_note", o_m_tlast, e.last);
            end
        end
    end

    // output backpressure
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_tick(bit strike);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, strike};
        do @(posedge i_clk); while (!o_s_tready);
        pending_samples.push_back(render_sample(strike));
    endtask

    task automatic write_reg(logic [2:0] regsel, logic [31:0] val);
        i_s_tvalid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (120) @(posedge i_clk);
        i_psel <= 1'b1; i_penable <= 1'b0; i_pwrite <= 1'b1;
        i_paddr <= {regsel, 2'b00}; i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0;
        case (regsel)
            hkv_pkg::REG_ROTATION:   rot_c = val & 32'h3FFF_FFFF;
            hkv_pkg::REG_FORCE_PEAK: force_pk = val & 32'h7FFF_FFFF;
            hkv_pkg::REG_FALL:       fall_f = val & 32'h1FFF_FFFF;
            hkv_pkg::REG_RISE_FALL:  rf_f = val & 32'h1FFF_FFFF;
            hkv_pkg::REG_KNOCK_ROT:  knock_rot = val & 32'h3FFF_FFFF;
            hkv_pkg::REG_KNOCK_RAT:  knock_rat = val & 32'h1FFF_FFFF;
            hkv_pkg::REG_SEED:       seed_r = val;
            hkv_pkg::REG_LENGTH:     len_r = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick(logic [31:0] hi);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    task automatic random_setup();
        write_reg(hkv_pkg::REG_ROTATION, pick(32'd536870912));
        write_reg(hkv_pkg::REG_FORCE_PEAK, pick(32'd1073741824));
        write_reg(hkv_pkg::REG_FALL, $urandom_range(0, 3) == 0 ? pick(32'd268435456)
                            : $urandom_range(260000000, 268435456));
        write_reg(hkv_pkg::REG_RISE_FALL, $urandom_range(0, 3) == 0 ? pick(32'd268435456)
                                 : $urandom_range(240000000, 268435456));
        write_reg(hkv_pkg::REG_KNOCK_ROT, pick(32'd536870912));
        write_reg(hkv_pkg::REG_KNOCK_RAT, pick(32'd268435456));
        write_reg(hkv_pkg::REG_SEED, $urandom_range(0, 7) == 0 ? 32'd0 : $urandom);
        case ($urandom_range(0, 7))
            0: write_reg(hkv_pkg::REG_LENGTH, 32'd65535);
            1: write_reg(hkv_pkg::REG_LENGTH, $urandom_range(0, 3));
            2: write_reg(hkv_pkg::REG_LENGTH, $urandom_range(470, 490));
            default: write_reg(hkv_pkg::REG_LENGTH, $urandom_range(4, 700));
        endcase
    endtask

    task automatic test_unconfigured();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_directed();
        write_reg(hkv_pkg::REG_LENGTH, 32'd2);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        write_reg(hkv_pkg::REG_ROTATION, 32'd536870912);
        write_reg(hkv_pkg::REG_FORCE_PEAK, 32'd1073741824);
        write_reg(hkv_pkg::REG_FALL, 32'd268435456);
        write_reg(hkv_pkg::REG_RISE_FALL, 32'd0);
        write_reg(hkv_pkg::REG_KNOCK_ROT, 32'd536870912);
        write_reg(hkv_pkg::REG_KNOCK_RAT, 32'd268435456);
        write_reg(hkv_pkg::REG_SEED, 32'hFFFF_FFFF);
        write_reg(hkv_pkg::REG_LENGTH, 32'd65535);
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        write_reg(hkv_pkg::REG_SEED, 32'd0);
        write_reg(hkv_pkg::REG_KNOCK_ROT, 32'd0);
        write_reg(hkv_pkg::REG_LENGTH, 32'd481);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        repeat (12) send_tick($urandom_range(0, 9) == 0);
    endtask

    task automatic test_random(int settings, int per_setting);
        repeat (settings) begin
            random_setup();
            send_tick(1'b1);
            repeat (per_setting) begin
                if (idx >= len_r) send_tick($urandom_range(0, 2) == 0);
                else send_tick($urandom_range(0, 79) == 0);
            end
        end
    endtask

    initial begin
        rot_c = 0; force_pk = 0; fall_f = 0; rf_f = 0;
        knock_rot = 0; knock_rat = 0; seed_r = 1; len_r = 0;
        clear_voice();
        noise = 32'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unconfigured();
        test_directed();
        test_backpressure();
        test_random(8, 220);
        calm = 1'b1;
        test_random(1, 120);
        i_s_tvalid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
